[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked property, also active during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[hw/rtl/vmbd_pkg.sv]
// Package for the video memory block DMA unit: action codes, widths,
// transaction structs. No dependencies.
package vmbd_pkg;

   localparam int BURST_BYTES = 16;
   localparam int CNT_W       = $clog2(BURST_BYTES + 1);

   localparam logic [15:0] VRAM_BASE = 16'h8000;
   localparam logic [15:0] VRAM_LAST = 16'h9FFF;
   localparam logic [7:0]  STATUS_DONE = 8'hFF;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_BLANK   = 2'd1,
      ACT_CONTROL = 2'd2
   } action_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] control_byte;
      logic [7:0] source_high;
      logic [7:0] source_low;
      logic [7:0] dest_high;
      logic [7:0] dest_low;
   } item_type;

   typedef struct packed {
      logic        copy_valid;
      logic [15:0] copy_source;
      logic [15:0] copy_dest;
      logic [7:0]  status_byte;
      logic        busy_res;
   } result_type;

endpackage

[hw/rtl/vmbd_engine.sv]
// Transfer state and per-transaction update for the video memory block DMA.
// Depends on vmbd_pkg.
module vmbd_engine
   import vmbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       enable,
   input  item_type   item,
   output result_type result
);

   localparam logic [CNT_W-1:0] BURST_LIMIT = CNT_W'(BURST_BYTES);

   logic             active_ff,  active_in;
   logic             running_ff, running_in;
   logic             blank_ff,   blank_in;
   logic             phase_ff,   phase_in;
   logic [CNT_W-1:0] count_ff,   count_in;
   logic [15:0]      src_ff,     src_in;
   logic [15:0]      dst_ff,     dst_in;
   logic [11:0]      left_ff,    left_in;
   logic [7:0]       mirror_ff,  mirror_in;
   logic [7:0]       blocks;
   logic             copy;

   always_comb begin
      active_in  = active_ff;
      running_in = running_ff;
      blank_in   = blank_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      left_in    = left_ff;
      mirror_in  = mirror_ff;
      copy       = 1'b0;
      blocks     = 8'd0;
      case (item.action)
         ACT_TICK: begin
            if (active_ff && running_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
               end else begin
                  phase_in = 1'b0;
                  copy     = 1'b1;
                  src_in   = src_ff + 16'd1;
                  dst_in   = dst_ff + 16'd1;
                  count_in = (count_ff == BURST_LIMIT) ? count_ff : count_ff + CNT_W'(1);
                  left_in  = left_ff - 12'd1;
                  if (left_in == 12'd0 || dst_in > VRAM_LAST) begin
                     active_in  = 1'b0;
                     running_in = 1'b0;
                     mirror_in  = STATUS_DONE;
                  end else begin
                     if (blank_ff && count_in >= BURST_LIMIT) begin
                        running_in = 1'b0;
                        count_in   = '0;
                     end
                     blocks    = left_in[11:4] - 8'd1;
                     mirror_in = {mirror_ff[7], blocks[6:0]};
                  end
               end
            end
         end
         ACT_BLANK: begin
            if (active_ff && blank_ff && enable) begin
               running_in = 1'b1;
               count_in   = '0;
            end
         end
         ACT_CONTROL: begin
            if (enable) begin
               if (!item.control_byte[7] && active_ff) begin
                  active_in = 1'b0;
               end else begin
                  src_in     = {item.source_high, item.source_low[7:4], 4'h0};
                  dst_in     = VRAM_BASE | {3'b000, item.dest_high[4:0],
                                            item.dest_low[7:4], 4'h0};
                  left_in    = {8'({1'b0, item.control_byte[6:0]}) + 8'd1, 4'h0};
                  active_in  = 1'b1;
                  running_in = !item.control_byte[7];
                  blank_in   = item.control_byte[7];
                  phase_in   = 1'b0;
                  count_in   = '0;
                  mirror_in  = item.control_byte;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.copy_valid  = copy;
      result.copy_source = copy ? src_ff : 16'd0;
      result.copy_dest   = copy ? dst_ff : 16'd0;
      result.status_byte = mirror_in;
      result.busy_res    = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         running_ff <= 1'b0;
         blank_ff   <= 1'b0;
         phase_ff   <= 1'b0;
         count_ff   <= '0;
         src_ff     <= 16'd0;
         dst_ff     <= 16'd0;
         left_ff    <= 12'd0;
         mirror_ff  <= 8'd0;
      end else if (fire) begin
         active_ff  <= active_in;
         running_ff <= running_in;
         blank_ff   <= blank_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         left_ff    <= left_in;
         mirror_ff  <= mirror_in;
      end
   end

endmodule

[hw/rtl/video_memory_block_dma_unit.sv]
// Top level of the video memory block DMA unit: input register, engine,
// result register and enable register. Depends on vmbd_pkg, vmbd_engine.
//
// Block copy engine into video memory. A control transaction starts (or, in
// general mode while active, cancels) a transfer; a blank transaction arms a
// 16-byte burst in blank mode; a tick transaction issues one byte-copy every
// second tick. Every request transaction yields exactly one response. The unit
// takes one transaction per clock unless req_stall holds it off; a request
// passes through the input register, then the result register, to its response,
// with the transfer state updated once per transaction in the engine between the two.
module video_memory_block_dma_unit
   import vmbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_control_byte,
   input  logic [7:0]  req_source_high,
   input  logic [7:0]  req_source_low,
   input  logic [7:0]  req_dest_high,
   input  logic [7:0]  req_dest_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_copy_valid,
   output logic [15:0] rsp_copy_source,
   output logic [15:0] rsp_copy_dest,
   output logic [7:0]  rsp_status_byte,
   output logic        rsp_busy_res,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic       in_valid_ff,  in_valid_in;
   item_type   item_ff,      item_in;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff,    result_in;
   result_type eng_result;
   logic       enable_ff;
   logic       advance;
   logic       fire;
   logic       accept;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      item_in      = item_ff;
      if (accept) begin
         item_in = '{action:       req_action,
                     control_byte: req_control_byte,
                     source_high:  req_source_high,
                     source_low:   req_source_low,
                     dest_high:    req_dest_high,
                     dest_low:     req_dest_low};
      end
      out_valid_in = fire || (out_valid_ff && rsp_stall);
      result_in    = fire ? eng_result : result_ff;
   end

   vmbd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .enable (enable_ff),
      .item   (item_ff),
      .result (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_copy_valid  = result_ff.copy_valid;
   assign rsp_copy_source = result_ff.copy_source;
   assign rsp_copy_dest   = result_ff.copy_dest;
   assign rsp_status_byte = result_ff.status_byte;
   assign rsp_busy_res    = result_ff.busy_res;

endmodule

[hw/rtl/vmbd_checker.sv]
// Port-level checks for the video memory block DMA unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module vmbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_copy_valid,
   input logic [15:0] rsp_copy_source,
   input logic [15:0] rsp_copy_dest,
   input logic [7:0]  rsp_status_byte,
   input logic        rsp_busy_res
);

   `ASSERT_CLK(rsp_hold_a, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_copy_valid)
         && $stable(rsp_copy_source) && $stable(rsp_copy_dest)
         && $stable(rsp_status_byte) && $stable(rsp_busy_res))
   `ASSERT_CLK(dest_in_vram_a, clock, reset,
      rsp_valid && rsp_copy_valid |-> rsp_copy_dest[15:13] == 3'b100)
   `ASSERT_CLK(idle_addr_zero_a, clock, reset,
      rsp_valid && !rsp_copy_valid |-> rsp_copy_source == 16'd0 && rsp_copy_dest == 16'd0)
   `ASSERT_ALWAYS(reset_clears_a, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind video_memory_block_dma_unit vmbd_checker u_vmbd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_copy_valid  (rsp_copy_valid),
   .rsp_copy_source (rsp_copy_source),
   .rsp_copy_dest   (rsp_copy_dest),
   .rsp_status_byte (rsp_status_byte),
   .rsp_busy_res    (rsp_busy_res)
);
